// ----- rtl/plob_pkg.sv -----
// Package for the price-level order book: command and status codes, shared types.
// No dependencies.
package plob_pkg;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_REMQ  = 2'd1;
    localparam logic [1:0] CMD_REML  = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic [3:0] ST_CROSSED  = 4'd0;
    localparam logic [3:0] ST_ADDED    = 4'd1;
    localparam logic [3:0] ST_CREATED  = 4'd2;
    localparam logic [3:0] ST_REDUCED  = 4'd3;
    localparam logic [3:0] ST_REMOVED  = 4'd4;
    localparam logic [3:0] ST_OVERDRAW = 4'd5;
    localparam logic [3:0] ST_UNKNOWN  = 4'd6;
    localparam logic [3:0] ST_FOUND    = 4'd7;
    localparam logic [3:0] ST_NOTFOUND = 4'd8;
    localparam logic [3:0] ST_FULL     = 4'd9;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] level_size;
        logic [31:0] best_bid_price;
        logic        best_bid_valid;
        logic [31:0] best_ask_price;
        logic        best_ask_valid;
    } result_t;

endpackage

// ----- rtl/plob_if.sv -----
// Valid/ready channel interface carrying one payload of a parameter type.
// No dependencies.
interface plob_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/plob_side_mem.sv -----
// One side of the book: price/size memory with a synchronous read port and a used-bit vector.
// No dependencies.
module plob_side_mem #(
    parameter int LEVELS = 64,
    parameter int AW     = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_price,
    output logic [31:0]   rd_size,
    output logic          rd_used,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_price,
    input  logic [31:0]   wr_size,
    input  logic          used_set,
    input  logic          used_clr,
    input  logic [AW-1:0] used_addr
);
    logic [63:0]       mem [LEVELS];
    logic [LEVELS-1:0] used_reg;
    logic [63:0]       rd_reg;
    logic              rd_used_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_price, wr_size};
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            rd_used_reg <= 1'b0;
        end
        else
        begin
            rd_used_reg <= used_reg[rd_addr];
            if (used_set)
            begin
                used_reg[used_addr] <= 1'b1;
            end
            else if (used_clr)
            begin
                used_reg[used_addr] <= 1'b0;
            end
        end
    end

    assign rd_price = rd_reg[63:32];
    assign rd_size  = rd_reg[31:0];
    assign rd_used  = rd_used_reg;
endmodule

// ----- rtl/price_level_order_book.sv -----
// Price-level order book: one command in, one result out.
// Each command makes one find pass over both side memories; a removal then
// rescans both sides to rebuild the best prices. A new command is accepted only
// once the last result is registered. The scan over the single read port sets the pace.
// Reset clears the used bits and best prices at once; no clearing pass is needed.
// Depends on plob_pkg, plob_if, plob_side_mem.
module price_level_order_book #(
    parameter int LEVELS = 64
) (
    input  logic clk,
    input  logic rst_n,
    plob_if.sink   in_ch,
    plob_if.source out_ch
);
    import plob_pkg::*;

    localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FIND = 3'd1;
    localparam logic [2:0] S_ACT  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]    state_reg, state_next;
    cmd_t          cmd_reg;
    logic [AW:0]   cnt_reg;          // read address issue counter
    logic [AW:0]   rcnt_reg;         // address of data arriving
    logic          rvld_reg;
    logic [31:0]   hit_bsz_reg, hit_asz_reg;
    logic          hit_b_reg, hit_a_reg;
    logic [AW-1:0] hit_ai_reg, hit_bi_reg;
    logic          route_ask_reg, route_bid_reg;
    logic [32:0]   best_bid_reg, best_ask_reg;
    logic [32:0]   scan_bid_reg, scan_ask_reg;
    logic          free_b_reg, free_a_reg;
    logic [AW-1:0] free_bi_reg, free_ai_reg;
    logic [3:0]    st_reg;           // status held until the result register frees up
    logic [31:0]   size_reg;         // queried size held alongside it
    result_t       res_reg;
    logic          out_vld_reg;

    logic [31:0] b_price, b_size, a_price, a_size;
    logic        b_used, a_used;
    logic        b_wr, a_wr, b_set, a_set, b_clr, a_clr;
    logic [AW-1:0] wr_idx;
    logic [31:0] wr_size;

    plob_side_mem #(.LEVELS(LEVELS), .AW(AW)) u_bid (
        .clk(clk), .rst_n(rst_n), .rd_addr(cnt_reg[AW-1:0]),
        .rd_price(b_price), .rd_size(b_size), .rd_used(b_used),
        .wr_en(b_wr), .wr_addr(wr_idx), .wr_price(cmd_reg.price), .wr_size(wr_size),
        .used_set(b_set), .used_clr(b_clr), .used_addr(wr_idx)
    );

    plob_side_mem #(.LEVELS(LEVELS), .AW(AW)) u_ask (
        .clk(clk), .rst_n(rst_n), .rd_addr(cnt_reg[AW-1:0]),
        .rd_price(a_price), .rd_size(a_size), .rd_used(a_used),
        .wr_en(a_wr), .wr_addr(wr_idx), .wr_price(cmd_reg.price), .wr_size(wr_size),
        .used_set(a_set), .used_clr(a_clr), .used_addr(wr_idx)
    );

    // Action decode, evaluated in S_ACT once the find pass is complete.
    logic        is_add, ask_side, do_hit, do_free, crossed;
    logic [31:0] h_size;
    logic [32:0] sum33;
    logic [3:0]  st;
    logic        upd_bb, upd_ba, rescan;

    always_comb
    begin
        is_add   = (cmd_reg.cmd == CMD_ADD);
        ask_side = is_add ? cmd_reg.side : route_ask_reg;
        do_hit   = ask_side ? hit_a_reg : hit_b_reg;
        do_free  = ask_side ? free_a_reg : free_b_reg;
        h_size   = ask_side ? hit_asz_reg : hit_bsz_reg;
        wr_idx   = do_hit ? (ask_side ? hit_ai_reg : hit_bi_reg)
                          : (ask_side ? free_ai_reg : free_bi_reg);
        sum33    = {1'b0, h_size} + {1'b0, cmd_reg.quantity};
        crossed  = cmd_reg.side ? (best_bid_reg[32] && cmd_reg.price <= best_bid_reg[31:0])
                                : (best_ask_reg[32] && cmd_reg.price >= best_ask_reg[31:0]);
        st = ST_UNKNOWN;
        wr_size = cmd_reg.quantity;
        b_wr = 1'b0; a_wr = 1'b0; b_set = 1'b0; a_set = 1'b0;
        b_clr = 1'b0; a_clr = 1'b0;
        upd_bb = 1'b0; upd_ba = 1'b0; rescan = 1'b0;
        unique case (cmd_reg.cmd)
            CMD_ADD:
            begin
                if (crossed)
                begin
                    st = ST_CROSSED;
                end
                else if (do_hit)
                begin
                    st = ST_ADDED;
                    wr_size = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
                    b_wr = !ask_side; a_wr = ask_side;
                end
                else if (do_free)
                begin
                    st = ST_CREATED;
                    b_wr = !ask_side; a_wr = ask_side;
                    b_set = !ask_side; a_set = ask_side;
                    upd_bb = !ask_side && (!best_bid_reg[32] || cmd_reg.price > best_bid_reg[31:0]);
                    upd_ba = ask_side && (!best_ask_reg[32] || cmd_reg.price < best_ask_reg[31:0]);
                end
                else
                begin
                    st = ST_FULL;
                end
            end
            CMD_QUERY:
            begin
                st = ((route_ask_reg || route_bid_reg) && do_hit) ? ST_FOUND : ST_NOTFOUND;
            end
            default:
            begin
                if ((route_ask_reg || route_bid_reg) && do_hit)
                begin
                    if (cmd_reg.cmd == CMD_REML || h_size == cmd_reg.quantity)
                    begin
                        st = ST_REMOVED;
                        b_clr = !ask_side; a_clr = ask_side;
                        rescan = 1'b1;
                    end
                    else if (h_size > cmd_reg.quantity)
                    begin
                        st = ST_REDUCED;
                        wr_size = h_size - cmd_reg.quantity;
                        b_wr = !ask_side; a_wr = ask_side;
                    end
                    else
                    begin
                        st = ST_OVERDRAW;
                    end
                end
            end
        endcase
        if (state_reg != S_ACT)
        begin
            b_wr = 1'b0; a_wr = 1'b0; b_set = 1'b0; a_set = 1'b0;
            b_clr = 1'b0; a_clr = 1'b0;
        end
    end

    logic pass_done;
    assign pass_done = rvld_reg && (rcnt_reg == (AW+1)'(LEVELS - 1));

    logic sweep;
    assign sweep = (state_reg == S_FIND || state_reg == S_SCAN) && cnt_reg < (AW+1)'(LEVELS);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_ch.valid) state_next = S_FIND;
            S_FIND: if (pass_done) state_next = S_ACT;
            S_ACT:  state_next = rescan ? S_SCAN : S_OUT;
            S_SCAN: if (pass_done) state_next = S_OUT;
            S_OUT:  if (!out_vld_reg || out_ch.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = out_vld_reg;
    assign out_ch.data  = res_reg;

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            cmd_reg <= in_ch.data;
            route_ask_reg <= best_ask_reg[32] && in_ch.data.price >= best_ask_reg[31:0];
            route_bid_reg <= !(best_ask_reg[32] && in_ch.data.price >= best_ask_reg[31:0])
                             && best_bid_reg[32] && in_ch.data.price <= best_bid_reg[31:0];
        end
        // Find pass: record matching and lowest free slot on each side.
        if (state_reg == S_IDLE)
        begin
            hit_b_reg <= 1'b0; hit_a_reg <= 1'b0;
            free_b_reg <= 1'b0; free_a_reg <= 1'b0;
        end
        else if (state_reg == S_FIND && rvld_reg)
        begin
            if (b_used && b_price == cmd_reg.price)
            begin
                hit_b_reg <= 1'b1; hit_bi_reg <= rcnt_reg[AW-1:0]; hit_bsz_reg <= b_size;
            end
            if (a_used && a_price == cmd_reg.price)
            begin
                hit_a_reg <= 1'b1; hit_ai_reg <= rcnt_reg[AW-1:0]; hit_asz_reg <= a_size;
            end
            if (!b_used && !free_b_reg)
            begin
                free_b_reg <= 1'b1; free_bi_reg <= rcnt_reg[AW-1:0];
            end
            if (!a_used && !free_a_reg)
            begin
                free_a_reg <= 1'b1; free_ai_reg <= rcnt_reg[AW-1:0];
            end
        end
        // Hold status and size here; the result register may still carry
        // the previous transfer.
        if (state_reg == S_ACT)
        begin
            scan_bid_reg <= '0; scan_ask_reg <= '0;
            st_reg       <= st;
            size_reg     <= (st == ST_FOUND) ? h_size : 32'd0;
        end
        else if (state_reg == S_SCAN && rvld_reg)
        begin
            if (b_used && (!scan_bid_reg[32] || b_price > scan_bid_reg[31:0]))
                scan_bid_reg <= {1'b1, b_price};
            if (a_used && (!scan_ask_reg[32] || a_price < scan_ask_reg[31:0]))
                scan_ask_reg <= {1'b1, a_price};
        end
        if (state_reg == S_OUT && (!out_vld_reg || out_ch.ready))
        begin
            res_reg.status         <= st_reg;
            res_reg.level_size     <= size_reg;
            res_reg.best_bid_price <= best_bid_reg[31:0];
            res_reg.best_bid_valid <= best_bid_reg[32];
            res_reg.best_ask_price <= best_ask_reg[31:0];
            res_reg.best_ask_valid <= best_ask_reg[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            rcnt_reg     <= '0;
            rvld_reg     <= 1'b0;
            best_bid_reg <= '0;
            best_ask_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Address sweep: issue LEVELS reads, data follows in the next cycle.
            rvld_reg <= sweep;
            if (sweep)
            begin
                rcnt_reg <= cnt_reg;
                cnt_reg  <= cnt_reg + 1'b1;
            end
            else if (state_reg == S_IDLE || state_reg == S_ACT)
            begin
                cnt_reg <= '0;
            end
            if (state_reg == S_ACT)
            begin
                if (upd_bb) best_bid_reg <= {1'b1, cmd_reg.price};
                if (upd_ba) best_ask_reg <= {1'b1, cmd_reg.price};
            end
            if (state_reg == S_SCAN && pass_done)
            begin
                // Last entry folded in here alongside the registered scan.
                best_bid_reg <= (b_used && (!scan_bid_reg[32] || b_price > scan_bid_reg[31:0]))
                                ? {1'b1, b_price} : scan_bid_reg;
                best_ask_reg <= (a_used && (!scan_ask_reg[32] || a_price < scan_ask_reg[31:0]))
                                ? {1'b1, a_price} : scan_ask_reg;
            end
            if (state_reg == S_OUT && (!out_vld_reg || out_ch.ready))
                out_vld_reg <= 1'b1;
            else if (out_ch.valid && out_ch.ready)
                out_vld_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_cross: assert property (@(posedge clk) disable iff (!rst_n)
        (best_bid_reg[32] && best_ask_reg[32]) |-> best_bid_reg[31:0] < best_ask_reg[31:0])
        else $error("book crossed");
    a_one_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !((b_wr || b_clr) && (a_wr || a_clr)))
        else $error("both sides written");
    a_scan_after_act: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && $past(state_reg) != S_SCAN) |-> $past(state_reg) == S_ACT)
        else $error("scan entered out of order");
`endif
endmodule

// ----- sim/tb_price_level_order_book.sv -----
// Testbench for the price-level order book: directed table, random commands, then a bid fill.
// Each result is checked against a behavioral copy of the book kept in the bench.
// Depends on plob_pkg, plob_if and price_level_order_book.
module tb_price_level_order_book;
    timeunit 1ns;
    timeprecision 1ps;

    import plob_pkg::*;

    localparam int LEVELS = 64;
    localparam int N_RANDOM = 1900;
    localparam logic [31:0] MAXV = 32'hFFFF_FFFF;

    logic clk;
    logic rst_n;

    plob_if #(.payload_t(cmd_t))    cmd_ch (clk);
    plob_if #(.payload_t(result_t)) res_ch (clk);

    price_level_order_book #(.LEVELS(LEVELS)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch.sink),
        .out_ch (res_ch.source)
    );

    // Shadow copy of the book.
    logic [31:0] bid_px [LEVELS];
    logic [31:0] bid_sz [LEVELS];
    logic        bid_used [LEVELS];
    logic [31:0] ask_px [LEVELS];
    logic [31:0] ask_sz [LEVELS];
    logic        ask_used [LEVELS];
    logic [31:0] best_bid_px, best_ask_px;
    logic        best_bid_ok, best_ask_ok;

    result_t expected_results [$];
    int      error_count;
    logic    sending_done;
    logic    hold_rx;   // long receiver hold-off

    // Directed stimulus row: a command plus an optional typed-in result.
    typedef struct {
        cmd_t    c;
        logic    has_exp;
        result_t r;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    function automatic int find_level(input logic side_ask, input logic [31:0] p);
        for (int i = 0; i < LEVELS; i++)
        begin
            if (side_ask ? (ask_used[i] && ask_px[i] == p) : (bid_used[i] && bid_px[i] == p))
                return i;
        end
        return -1;
    endfunction

    function automatic int count_levels(input logic side_ask);
        int n;
        n = 0;
        for (int i = 0; i < LEVELS; i++)
            n += side_ask ? ask_used[i] : bid_used[i];
        return n;
    endfunction

    function automatic logic ask_ok_or(input int i);
        return best_ask_ok && !(ask_px[i] < best_ask_px);
    endfunction

    function automatic void rescan_best();
        best_bid_ok = 1'b0; best_bid_px = '0;
        best_ask_ok = 1'b0; best_ask_px = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            if (bid_used[i] && (!best_bid_ok || bid_px[i] > best_bid_px))
            begin
                best_bid_ok = 1'b1; best_bid_px = bid_px[i];
            end
            if (ask_used[i] && (!ask_ok_or(i)))
            begin
                best_ask_ok = 1'b1; best_ask_px = ask_px[i];
            end
        end
    endfunction

    task automatic book_reset();
        for (int i = 0; i < LEVELS; i++)
        begin
            bid_used[i] = 1'b0; ask_used[i] = 1'b0;
            bid_px[i] = '0; bid_sz[i] = '0; ask_px[i] = '0; ask_sz[i] = '0;
        end
        best_bid_ok = 1'b0; best_bid_px = '0;
        best_ask_ok = 1'b0; best_ask_px = '0;
    endtask

    // Apply one command to the shadow book and return the result it should give.
    function automatic result_t predict_book(input cmd_t c);
        result_t r;
        int s;
        logic to_ask, to_bid;
        logic [32:0] sum;
        r = '0;
        if (c.cmd == CMD_ADD)
        begin
            if (c.side == 1'b0 ? (best_ask_ok && c.price >= best_ask_px)
                               : (best_bid_ok && c.price <= best_bid_px))
                r.status = ST_CROSSED;
            else
            begin
                s = find_level(c.side, c.price);
                if (s >= 0)
                begin
                    sum = (c.side ? ask_sz[s] : bid_sz[s]) + {1'b0, c.quantity};
                    if (sum[32]) sum[31:0] = MAXV;
                    if (c.side) ask_sz[s] = sum[31:0]; else bid_sz[s] = sum[31:0];
                    r.status = ST_ADDED;
                end
                else if (count_levels(c.side) == LEVELS)
                    r.status = ST_FULL;
                else
                begin
                    for (s = 0; s < LEVELS; s++)
                        if (!(c.side ? ask_used[s] : bid_used[s])) break;
                    if (c.side)
                    begin
                        ask_used[s] = 1'b1; ask_px[s] = c.price; ask_sz[s] = c.quantity;
                        if (!best_ask_ok || c.price < best_ask_px)
                        begin
                            best_ask_ok = 1'b1; best_ask_px = c.price;
                        end
                    end
                    else
                    begin
                        bid_used[s] = 1'b1; bid_px[s] = c.price; bid_sz[s] = c.quantity;
                        if (!best_bid_ok || c.price > best_bid_px)
                        begin
                            best_bid_ok = 1'b1; best_bid_px = c.price;
                        end
                    end
                    r.status = ST_CREATED;
                end
            end
        end
        else
        begin
            to_ask = best_ask_ok && c.price >= best_ask_px;
            to_bid = !to_ask && best_bid_ok && c.price <= best_bid_px;
            s = (to_ask || to_bid) ? find_level(to_ask, c.price) : -1;
            if (c.cmd == CMD_QUERY)
            begin
                r.status = (s >= 0) ? ST_FOUND : ST_NOTFOUND;
                if (s >= 0) r.level_size = to_ask ? ask_sz[s] : bid_sz[s];
            end
            else if (s < 0)
                r.status = ST_UNKNOWN;
            else
            begin
                logic [31:0] sz;
                sz = to_ask ? ask_sz[s] : bid_sz[s];
                if (c.cmd == CMD_REML || sz == c.quantity)
                begin
                    if (to_ask) ask_used[s] = 1'b0; else bid_used[s] = 1'b0;
                    r.status = ST_REMOVED;
                    rescan_best();
                end
                else if (sz > c.quantity)
                begin
                    if (to_ask) ask_sz[s] = sz - c.quantity; else bid_sz[s] = sz - c.quantity;
                    r.status = ST_REDUCED;
                end
                else
                    r.status = ST_OVERDRAW;
            end
        end
        r.best_bid_valid = best_bid_ok;
        r.best_bid_price = best_bid_ok ? best_bid_px : '0;
        r.best_ask_valid = best_ask_ok;
        r.best_ask_price = best_ask_ok ? best_ask_px : '0;
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return 0;
        if (k < 90) return $urandom_range(1, 3);
        if (k < 98) return $urandom_range(4, 20);
        return $urandom_range(50, 200);
    endfunction

    // Hand one command over and file what it should produce. With no gap,
    // valid stays high into the next transfer.
    task automatic send_cmd(input cmd_t c, input logic has_exp, input result_t typed);
        result_t p;
        int g;
        g = gap_len();
        if (g > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do @(posedge clk); while (!cmd_ch.ready);
        p = predict_book(c);
        if (has_exp && p !== typed)
            report_mismatch("typed-in row status", p.status, typed.status);
        expected_results.push_back(has_exp ? typed : p);
    endtask

    function automatic cmd_t mk(input logic [1:0] op, input logic sd,
                                input logic [31:0] p, input logic [31:0] q);
        cmd_t c;
        c.cmd = op; c.side = sd; c.price = p; c.quantity = q;
        return c;
    endfunction

    function automatic result_t rs(input logic [3:0] st, input logic [31:0] sz,
                                   input logic bv, input logic [31:0] bp,
                                   input logic av, input logic [31:0] ap);
        result_t r;
        r.status = st; r.level_size = sz;
        r.best_bid_valid = bv; r.best_bid_price = bp;
        r.best_ask_valid = av; r.best_ask_price = ap;
        return r;
    endfunction

    // Random price near a small band so levels collide and cross often.
    function automatic logic [31:0] rand_price(input logic sd);
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return $urandom();
        if (k == 1) return sd ? MAXV - $urandom_range(0, 3) : $urandom_range(0, 3);
        return sd ? 32'd1000 + $urandom_range(0, 40) : 32'd960 + $urandom_range(0, 40);
    endfunction

    function automatic logic [31:0] rand_qty();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 32'd0;
        if (k == 1) return $urandom();
        if (k == 2) return MAXV - $urandom_range(0, 5);
        return $urandom_range(1, 50);
    endfunction

    // Stimulus: directed table, then random commands, then a fill of one side.
    initial
    begin
        row_t  rows [$];
        cmd_t  c;
        int    k;
        logic  sd;

        error_count  = 0;
        sending_done = 1'b0;
        hold_rx      = 1'b0;
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        book_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty book: query and removes find nothing.
        rows.push_back('{mk(CMD_QUERY, 1'b0, 32'd5, 32'd0), 1'b1,
                         rs(ST_NOTFOUND, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(CMD_REMQ, 1'b1, MAXV, MAXV), 1'b1,
                         rs(ST_UNKNOWN, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(CMD_REML, 1'b0, 32'd0, 32'd0), 1'b1,
                         rs(ST_UNKNOWN, 0, 0, 0, 0, 0)});
        rows.push_back('{mk(CMD_ADD, 1'b0, 32'd100, MAXV), 1'b1,
                         rs(ST_CREATED, 0, 1, 100, 0, 0)});
        // Saturating add on an existing level.
        rows.push_back('{mk(CMD_ADD, 1'b0, 32'd100, 32'd7), 1'b1,
                         rs(ST_ADDED, 0, 1, 100, 0, 0)});
        rows.push_back('{mk(CMD_QUERY, 1'b1, 32'd100, 32'd0), 1'b1,
                         rs(ST_FOUND, MAXV, 1, 100, 0, 0)});
        rows.push_back('{mk(CMD_ADD, 1'b1, MAXV, 32'd3), 1'b1,
                         rs(ST_CREATED, 0, 1, 100, 1, MAXV)});
        // Crossing on both sides.
        rows.push_back('{mk(CMD_ADD, 1'b1, 32'd100, 32'd1), 1'b1,
                         rs(ST_CROSSED, 0, 1, 100, 1, MAXV)});
        rows.push_back('{mk(CMD_ADD, 1'b0, MAXV, 32'd1), 1'b1,
                         rs(ST_CROSSED, 0, 1, 100, 1, MAXV)});
        rows.push_back('{mk(CMD_ADD, 1'b0, 32'd0, 32'd0), 1'b1,
                         rs(ST_CREATED, 0, 1, 100, 1, MAXV)});
        rows.push_back('{mk(CMD_REMQ, 1'b0, MAXV, 32'd4), 1'b1,
                         rs(ST_OVERDRAW, 0, 1, 100, 1, MAXV)});
        rows.push_back('{mk(CMD_REMQ, 1'b1, MAXV, 32'd1), 1'b1,
                         rs(ST_REDUCED, 0, 1, 100, 1, MAXV)});
        rows.push_back('{mk(CMD_REMQ, 1'b0, MAXV, 32'd2), 1'b1,
                         rs(ST_REMOVED, 0, 1, 100, 0, 0)});
        // Zero quantity remove drops a zero-size level.
        rows.push_back('{mk(CMD_REMQ, 1'b1, 32'd0, 32'd0), 1'b1,
                         rs(ST_REMOVED, 0, 1, 100, 0, 0)});
        rows.push_back('{mk(CMD_REMQ, 1'b0, 32'd100, 32'd0), 1'b1,
                         rs(ST_REDUCED, 0, 1, 100, 0, 0)});
        rows.push_back('{mk(CMD_ADD, 1'b0, 32'd50, 32'd9), 1'b0, '0});
        rows.push_back('{mk(CMD_QUERY, 1'b0, 32'd75, 32'd0), 1'b0, '0});
        rows.push_back('{mk(CMD_REML, 1'b1, 32'd100, 32'd0), 1'b1,
                         rs(ST_REMOVED, 0, 1, 50, 0, 0)});
        rows.push_back('{mk(CMD_QUERY, 1'b0, 32'd50, 32'd0), 1'b1,
                         rs(ST_FOUND, 9, 1, 50, 0, 0)});
        rows.push_back('{mk(CMD_REML, 1'b0, 32'd50, 32'd0), 1'b1,
                         rs(ST_REMOVED, 0, 0, 0, 0, 0)});

        foreach (rows[i])
            send_cmd(rows[i].c, rows[i].has_exp, rows[i].r);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // Hold the receiver off once while commands keep coming.
            if (n == 300) hold_rx <= 1'b1;
            k  = $urandom_range(0, 99);
            sd = $urandom_range(0, 1);
            if (k < 45)
                c = mk(CMD_ADD, sd, rand_price(sd), rand_qty());
            else if (k < 65)
                c = mk(CMD_REMQ, $urandom_range(0, 1), rand_price(sd),
                       $urandom_range(0, 1) ? rand_qty() : $urandom_range(0, 60));
            else if (k < 78)
                c = mk(CMD_REML, $urandom_range(0, 1), rand_price(sd), $urandom());
            else
                c = mk(CMD_QUERY, $urandom_range(0, 1), rand_price(sd), $urandom());
            send_cmd(c, 1'b0, '0);
        end

        // Add LEVELS+1 bids with unique low prices to push the bid side toward full.
        for (int n = 0; n <= LEVELS; n++)
            send_cmd(mk(CMD_ADD, 1'b0, 32'd10 + n, 32'd1), 1'b0, '0);
        send_cmd(mk(CMD_QUERY, 1'b0, 32'd10, 32'd0), 1'b0, '0);
        cmd_ch.valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: random stalls, one long hold-off, check in order.
    initial
    begin
        result_t got, want;
        int hold_cnt;
        res_ch.ready = 1'b0;
        hold_cnt = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.data;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result status", got.status, 32'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.level_size !== want.level_size)
                        report_mismatch("level_size", got.level_size, want.level_size);
                    if (got.best_bid_price !== want.best_bid_price)
                        report_mismatch("best_bid_price", got.best_bid_price,
                                        want.best_bid_price);
                    if (got.best_bid_valid !== want.best_bid_valid)
                        report_mismatch("best_bid_valid", got.best_bid_valid,
                                        want.best_bid_valid);
                    if (got.best_ask_price !== want.best_ask_price)
                        report_mismatch("best_ask_price", got.best_ask_price,
                                        want.best_ask_price);
                    if (got.best_ask_valid !== want.best_ask_valid)
                        report_mismatch("best_ask_valid", got.best_ask_valid,
                                        want.best_ask_valid);
                end
            end
            if (hold_rx && hold_cnt < 2000)
            begin
                hold_cnt++;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // End of run: drain, then idle before reporting.
    initial
    begin
        @(posedge rst_n);
        wait (sending_done === 1'b1);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (4 * LEVELS + 20) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/plob_pkg.sv
rtl/plob_if.sv
rtl/plob_side_mem.sv
rtl/price_level_order_book.sv
sim/tb_price_level_order_book.sv
